// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset
`define ZAR_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define ZAR_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/zar_pkg.sv =====
`default_nettype none
package zar_pkg;

  localparam int SENSORS_DEF = 32;
  localparam int HISTORY_DEF = 3;

  localparam int TS_W       = 48;
  localparam int VAL_W      = 32;
  localparam int Z_W        = 24;
  localparam int CNT_W      = 32;
  localparam int SSD_W      = 64;
  localparam int SEC_W      = 39;
  localparam int DIV_W      = 64;
  localparam int SQ_IN_W    = 64;
  localparam int SQ_OUT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] STD_MIN    = 32'd7;
  localparam logic [63:0] MS_PER_SEC = 64'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_Z_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ALERTS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_SEC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SEC   = 3'd4;

  // Register reset values
  localparam logic [11:0] RST_Z_THRESHOLD  = 12'd640;
  localparam logic [15:0] RST_WARMUP_COUNT = 16'd20;
  localparam logic [1:0]  RST_MAX_ALERTS   = 2'd3;
  localparam logic [15:0] RST_COOLDOWN_SEC = 16'd30;
  localparam logic [15:0] RST_WINDOW_SEC   = 16'd60;

  // Outcome codes
  localparam logic [1:0] OUT_NONE     = 2'd0;
  localparam logic [1:0] OUT_ALERT    = 2'd1;
  localparam logic [1:0] OUT_SUPPRESS = 2'd2;

endpackage
`default_nettype wire

// ===== sv/zscore_anomaly_rate_limiter.sv =====
// Per-sensor z-score anomaly detector with alert rate limiting.
// Input channel (in_valid / in_stall): one sample per transaction, with the
// sensor index, a millisecond timestamp and a signed Q16.16 reading.
// Result channel (out_valid / out_stall): exactly one result per sample, in
// order: outcome, saturated Q8.16 z-score, mean and stddev after the update.
// Configuration (cfg_we / cfg_index / cfg_wdata) writes one register per
// cycle; write only while no sample is in flight.
// Per-sensor statistics live in one RAM word per sensor, read, updated and
// written back while one sample is in flight. Work is set by a shared
// one-bit-per-cycle 64-bit divider and a two-bit-per-cycle square root,
// plus, when |z| exceeds the threshold, a conversion of HISTORY + 2
// timestamps to seconds, one 12-bit digit per cycle by reciprocal
// multiplication. After reset a clearing pass zeroes every RAM word;
// in_stall is high during it. A finished result sits in the output
// register; the next sample is taken while it waits, and a stalled
// receiver holds the block only once the following result is ready.
`default_nettype none
`include "assert_macros.svh"
module zscore_anomaly_rate_limiter
  import zar_pkg::*;
#(
  parameter int SENSORS = SENSORS_DEF,
  parameter int HISTORY = HISTORY_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [4:0]            in_sensor_index,
  input  wire logic [TS_W-1:0]       in_time_ms,
  input  wire logic signed [VAL_W-1:0] in_sample_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_outcome,
  output logic signed [Z_W-1:0]      out_z_score,
  output logic signed [VAL_W-1:0]    out_mean_after,
  output logic [VAL_W-1:0]           out_stddev_after,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int FW  = $clog2(HISTORY + 1);
  localparam int KW  = $clog2(HISTORY + 2);
  localparam int HIW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int NS  = HISTORY + 2;
  localparam int E_W = CNT_W + VAL_W + SSD_W + HISTORY * TS_W + FW + TS_W + 1;
  localparam int MAG_W = 48;

  // ceil(2^32 / 1000): exact quotient for any 22-bit digit window
  localparam logic [22:0] SEC_RECIP = 23'd4294968;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_RD      = 5'd2;
  localparam logic [4:0] S_LOAD    = 5'd3;
  localparam logic [4:0] S_SDO_DIV = 5'd4;
  localparam logic [4:0] S_SDO_SQ  = 5'd5;
  localparam logic [4:0] S_ZCHK    = 5'd6;
  localparam logic [4:0] S_Z_DIV   = 5'd7;
  localparam logic [4:0] S_UPD     = 5'd8;
  localparam logic [4:0] S_M_DIV   = 5'd9;
  localparam logic [4:0] S_MUL     = 5'd10;
  localparam logic [4:0] S_ACC     = 5'd11;
  localparam logic [4:0] S_SDN_DIV = 5'd12;
  localparam logic [4:0] S_SDN_SQ  = 5'd13;
  localparam logic [4:0] S_POST    = 5'd14;
  localparam logic [4:0] S_SEC     = 5'd15;
  localparam logic [4:0] S_RATE    = 5'd16;
  localparam logic [4:0] S_WB      = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  // Configuration registers
  logic [11:0] thr_r;
  logic [15:0] warm_cnt_r, cool_r, win_r;
  logic [1:0]  max_r;

  // Control
  logic [4:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic          out_valid_r, out_valid_nxt;

  // Sample and entry working registers
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [TS_W-1:0]        time_r, time_nxt;
  logic signed [VAL_W-1:0] x_r, x_nxt;
  logic                   bad_r, bad_nxt, warm_r, warm_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0] mean_r, mean_nxt;
  logic [SSD_W-1:0]       ssd_r, ssd_nxt;
  logic [HISTORY-1:0][TS_W-1:0] hist_r, hist_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [TS_W-1:0]        last_r, last_nxt;
  logic                   has_r, has_nxt;
  logic [SQ_OUT_W-1:0]    sd_r, sd_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [31:0]            dmag_r, dmag_nxt;
  logic                   dneg_r, dneg_nxt;
  logic [63:0]            prod_r, prod_nxt;
  logic [SEC_W-1:0]       secs_r [NS];
  logic [SEC_W-1:0]       secs_nxt [NS];
  logic [KW-1:0]          k_r, k_nxt;
  logic [1:0]             outc_r, outc_nxt;
  logic [TS_W-1:0]        sec_v_r, sec_v_nxt;
  logic [9:0]             sec_rem_r, sec_rem_nxt;
  logic [TS_W-1:0]        sec_q_r, sec_q_nxt;
  logic [1:0]             sec_d_r, sec_d_nxt;

  // Output registers
  logic [1:0]              o_outc_r, o_outc_nxt;
  logic signed [Z_W-1:0]   o_z_r, o_z_nxt;
  logic signed [VAL_W-1:0] o_mean_r, o_mean_nxt;
  logic [VAL_W-1:0]        o_sd_r, o_sd_nxt;

  // Arithmetic unit handshakes
  logic             div_start_r, div_start_nxt, div_done;
  logic [DIV_W-1:0] div_a_r, div_a_nxt, div_b_r, div_b_nxt, div_q;
  logic             sq_start_r, sq_start_nxt, sq_done;
  logic [SQ_IN_W-1:0]  sq_a_r, sq_a_nxt;
  logic [SQ_OUT_W-1:0] sq_root;

  // RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [E_W-1:0] ram_wdata, ram_rdata;

  // Unpacked entry
  logic [CNT_W-1:0]        ent_cnt;
  logic signed [VAL_W-1:0] ent_mean;
  logic [SSD_W-1:0]        ent_ssd;
  logic [HISTORY-1:0][TS_W-1:0] ent_hist;
  logic [FW-1:0]           ent_fill;
  logic [TS_W-1:0]         ent_last;
  logic                    ent_has;

  // Datapath wires
  logic                  accept, in_bad;
  logic [31:0]           idx_ext;
  logic [AW+4:0]         idx_wide;
  logic signed [VAL_W:0] dev_w;
  logic [31:0]           dev_mag;
  logic [CNT_W-1:0]      n_w;
  logic signed [33:0]    quot_s, mean_sum;
  logic [SSD_W:0]        ssd_sum;
  logic [SSD_W-1:0]      ssd_new;
  logic [KW-1:0]         kn, kh;
  logic [TS_W-1:0]       sec_src;
  logic                  cool_w, allow_w;
  logic [FW-1:0]         recent_w;
  logic signed [Z_W-1:0] z_w;
  logic [21:0]           sec_v, sec_prod, sec_rem_full;
  logic [44:0]           sec_mul;
  logic [11:0]           sec_dig;
  logic [9:0]            sec_rem_w;
  logic [TS_W-1:0]       sec_q_w;

  function automatic logic elapsed_below(input logic [SEC_W-1:0] now_s,
                                         input logic [SEC_W-1:0] then_s,
                                         input logic [15:0] lim);
    logic [SEC_W-1:0] diff;
    diff = now_s - then_s;
    return (now_s >= then_s) && (diff < SEC_W'(lim));
  endfunction

  zar_ram #(.W(E_W), .D(SENSORS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  zar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  zar_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (sq_a_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Handshake and index decode
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_ext  = 32'(in_sensor_index);
  assign in_bad   = idx_ext >= 32'(SENSORS);
  assign idx_wide = (AW + 5)'(in_sensor_index);

  // RAM access: clearing pass after reset, write-back at the end of a sample
  assign ram_re    = (state_r == S_RD);
  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WB);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : idx_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 :
                     {has_r, last_r, fill_r, hist_r, ssd_r, mean_r, cnt_r};
  assign {ent_has, ent_last, ent_fill, ent_hist, ent_ssd, ent_mean, ent_cnt} = ram_rdata;

  // Deviation against the current mean
  assign dev_w   = $signed({x_r[VAL_W-1], x_r}) - $signed({mean_r[VAL_W-1], mean_r});
  assign dev_mag = dev_w[VAL_W] ? 32'(-dev_w) : dev_w[31:0];
  assign n_w     = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);

  assign quot_s   = dneg_r ? -$signed({2'b00, div_q[31:0]}) : $signed({2'b00, div_q[31:0]});
  assign mean_sum = $signed({{2{mean_r[VAL_W-1]}}, mean_r}) + quot_s;

  assign ssd_sum = {1'b0, ssd_r} + {1'b0, prod_r};
  assign ssd_new = ssd_sum[SSD_W] ? '1 : ssd_sum[SSD_W-1:0];

  // Timestamp to convert next: now, last alert, then history entries
  assign kn      = k_r + KW'(1);
  assign kh      = kn - KW'(2);
  assign sec_src = (kn == KW'(1)) ? last_r : hist_r[kh[HIW-1:0]];

  // Milliseconds to seconds: long division by 1000, one 12-bit digit a cycle
  assign sec_v        = {sec_rem_r, sec_v_r[TS_W-1:TS_W-12]};
  assign sec_mul      = sec_v * SEC_RECIP;
  assign sec_dig      = sec_mul[43:32];
  assign sec_prod     = sec_dig * MS_PER_SEC[9:0];
  assign sec_rem_full = sec_v - sec_prod;
  assign sec_rem_w    = sec_rem_full[9:0];
  assign sec_q_w      = {sec_q_r[TS_W-13:0], sec_dig};

  // Cooldown and window checks over the converted seconds
  always_comb begin
    recent_w = '0;
    for (int i = 0; i < HISTORY; i++) begin
      if ((FW'(i) < fill_r) && elapsed_below(secs_r[0], secs_r[i+2], win_r)) begin
        recent_w = recent_w + FW'(1);
      end
    end
    cool_w  = has_r && elapsed_below(secs_r[0], secs_r[1], cool_r);
    allow_w = !cool_w && (5'(recent_w) < 5'(max_r));
  end

  // Saturate the z-score
  always_comb begin
    if (neg_r) begin
      z_w = (mag_r > MAG_W'(24'h800000)) ? $signed(24'h800000) : $signed(24'(-mag_r));
    end else begin
      z_w = (mag_r > MAG_W'(24'h7FFFFF)) ? $signed(24'h7FFFFF) : $signed(mag_r[23:0]);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    time_nxt      = time_r;
    x_nxt         = x_r;
    bad_nxt       = bad_r;
    warm_nxt      = warm_r;
    cnt_nxt       = cnt_r;
    mean_nxt      = mean_r;
    ssd_nxt       = ssd_r;
    hist_nxt      = hist_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    has_nxt       = has_r;
    sd_nxt        = sd_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    prod_nxt      = prod_r;
    secs_nxt      = secs_r;
    k_nxt         = k_r;
    outc_nxt      = outc_r;
    sec_v_nxt     = sec_v_r;
    sec_rem_nxt   = sec_rem_r;
    sec_q_nxt     = sec_q_r;
    sec_d_nxt     = sec_d_r;
    div_start_nxt = 1'b0;
    div_a_nxt     = div_a_r;
    div_b_nxt     = div_b_r;
    sq_start_nxt  = 1'b0;
    sq_a_nxt      = sq_a_r;
    o_outc_nxt    = o_outc_r;
    o_z_nxt       = o_z_r;
    o_mean_nxt    = o_mean_r;
    o_sd_nxt      = o_sd_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(SENSORS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = idx_wide[AW-1:0];
          time_nxt  = in_time_ms;
          x_nxt     = in_sample_value;
          bad_nxt   = in_bad;
          state_nxt = in_bad ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cnt_nxt  = ent_cnt;
        mean_nxt = ent_mean;
        ssd_nxt  = ent_ssd;
        hist_nxt = ent_hist;
        fill_nxt = ent_fill;
        last_nxt = ent_last;
        has_nxt  = ent_has;
        mag_nxt  = '0;
        neg_nxt  = 1'b0;
        outc_nxt = OUT_NONE;
        warm_nxt = ent_cnt < CNT_W'(warm_cnt_r);
        if (ent_cnt < CNT_W'(warm_cnt_r)) begin
          state_nxt = S_UPD;
        end else if (ent_cnt < CNT_W'(2)) begin
          sd_nxt    = '0;
          state_nxt = S_ZCHK;
        end else begin
          div_start_nxt = 1'b1;
          div_a_nxt     = ent_ssd;
          div_b_nxt     = DIV_W'(ent_cnt - CNT_W'(1));
          state_nxt     = S_SDO_DIV;
        end
      end
      S_SDO_DIV, S_SDN_DIV: begin
        if (div_done) begin
          sq_start_nxt = 1'b1;
          sq_a_nxt     = div_q;
          state_nxt    = (state_r == S_SDO_DIV) ? S_SDO_SQ : S_SDN_SQ;
        end
      end
      S_SDO_SQ: begin
        if (sq_done) begin
          sd_nxt    = sq_root;
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (sd_r >= STD_MIN) begin
          neg_nxt       = dev_w[VAL_W];
          div_start_nxt = 1'b1;
          div_a_nxt     = {16'd0, dev_mag, 16'd0};
          div_b_nxt     = DIV_W'(sd_r);
          state_nxt     = S_Z_DIV;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_Z_DIV: begin
        if (div_done) begin
          mag_nxt   = div_q[MAG_W-1:0];
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cnt_nxt       = n_w;
        dmag_nxt      = dev_mag;
        dneg_nxt      = dev_w[VAL_W];
        div_start_nxt = 1'b1;
        div_a_nxt     = DIV_W'(dev_mag);
        div_b_nxt     = DIV_W'(n_w);
        state_nxt     = S_M_DIV;
      end
      S_M_DIV: begin
        if (div_done) begin
          mean_nxt  = mean_sum[VAL_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = dmag_r * (x_r == mean_r ? 32'd0 : dev_mag);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        ssd_nxt = ssd_new;
        if (cnt_r < CNT_W'(2)) begin
          sd_nxt    = '0;
          state_nxt = S_POST;
        end else begin
          div_start_nxt = 1'b1;
          div_a_nxt     = ssd_new;
          div_b_nxt     = DIV_W'(cnt_r - CNT_W'(1));
          state_nxt     = S_SDN_DIV;
        end
      end
      S_SDN_SQ: begin
        if (sq_done) begin
          sd_nxt    = sq_root;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (!warm_r && (mag_r > {28'd0, thr_r, 8'd0})) begin
          k_nxt       = '0;
          sec_v_nxt   = time_r;
          sec_rem_nxt = '0;
          sec_q_nxt   = '0;
          sec_d_nxt   = '0;
          state_nxt   = S_SEC;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_SEC: begin
        // Advance one digit; after the last, store and load the next timestamp
        sec_v_nxt   = {sec_v_r[TS_W-13:0], 12'd0};
        sec_rem_nxt = sec_rem_w;
        sec_q_nxt   = sec_q_w;
        sec_d_nxt   = sec_d_r + 2'd1;
        if (sec_d_r == 2'd3) begin
          secs_nxt[k_r] = sec_q_w[SEC_W-1:0];
          if (k_r == KW'(NS - 1)) begin
            state_nxt = S_RATE;
          end else begin
            k_nxt       = kn;
            sec_v_nxt   = sec_src;
            sec_rem_nxt = '0;
            sec_q_nxt   = '0;
          end
        end
      end
      S_RATE: begin
        if (allow_w) begin
          outc_nxt    = OUT_ALERT;
          hist_nxt[0] = time_r;
          for (int i = 1; i < HISTORY; i++) begin
            hist_nxt[i] = hist_r[i-1];
          end
          if (fill_r < FW'(HISTORY)) begin
            fill_nxt = fill_r + FW'(1);
          end
          last_nxt = time_r;
          has_nxt  = 1'b1;
        end else begin
          outc_nxt = OUT_SUPPRESS;
        end
        state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_outc_nxt    = bad_r ? OUT_NONE : outc_r;
          o_z_nxt       = bad_r ? '0 : z_w;
          o_mean_nxt    = bad_r ? '0 : mean_r;
          o_sd_nxt      = bad_r ? '0 : sd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      thr_r       <= RST_Z_THRESHOLD;
      warm_cnt_r  <= RST_WARMUP_COUNT;
      max_r       <= RST_MAX_ALERTS;
      cool_r      <= RST_COOLDOWN_SEC;
      win_r       <= RST_WINDOW_SEC;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
      sq_start_r  <= sq_start_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_Z_THRESHOLD:  thr_r      <= cfg_wdata[11:0];
          REG_WARMUP_COUNT: warm_cnt_r <= cfg_wdata;
          REG_MAX_ALERTS:   max_r      <= cfg_wdata[1:0];
          REG_COOLDOWN_SEC: cool_r     <= cfg_wdata;
          REG_WINDOW_SEC:   win_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    time_r    <= time_nxt;
    x_r       <= x_nxt;
    bad_r     <= bad_nxt;
    warm_r    <= warm_nxt;
    cnt_r     <= cnt_nxt;
    mean_r    <= mean_nxt;
    ssd_r     <= ssd_nxt;
    hist_r    <= hist_nxt;
    fill_r    <= fill_nxt;
    last_r    <= last_nxt;
    has_r     <= has_nxt;
    sd_r      <= sd_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    dmag_r    <= dmag_nxt;
    dneg_r    <= dneg_nxt;
    prod_r    <= prod_nxt;
    secs_r    <= secs_nxt;
    k_r       <= k_nxt;
    outc_r    <= outc_nxt;
    sec_v_r   <= sec_v_nxt;
    sec_rem_r <= sec_rem_nxt;
    sec_q_r   <= sec_q_nxt;
    sec_d_r   <= sec_d_nxt;
    div_a_r   <= div_a_nxt;
    div_b_r   <= div_b_nxt;
    sq_a_r    <= sq_a_nxt;
    o_outc_r  <= o_outc_nxt;
    o_z_r     <= o_z_nxt;
    o_mean_r  <= o_mean_nxt;
    o_sd_r    <= o_sd_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = o_outc_r;
  assign out_z_score      = o_z_r;
  assign out_mean_after   = o_mean_r;
  assign out_stddev_after = o_sd_r;

  // Entry writes happen only in the clearing pass or at write-back
  `ZAR_CHECK(a_ram_wr_state, !ram_we || state_r == S_CLEAR || state_r == S_WB, "stray RAM write")
  // A new result is loaded only from the completion state
  `ZAR_IMPLY(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "result out of sequence")
  // The divider is kicked only from a state that waits for it
  `ZAR_IMPLY(a_div_owner, div_start_r, state_r == S_SDO_DIV || state_r == S_Z_DIV || state_r == S_M_DIV || state_r == S_SDN_DIV, "divider started out of sequence")

endmodule
`default_nettype wire

// ===== sv/zar_ram.sv =====
`default_nettype none
module zar_ram #(
  parameter int W = 8,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/zar_div.sv =====
`default_nettype none
module zar_div
  import zar_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_W-1:0]  q_r, d_r;
  logic [DIV_W:0]    rem_r;
  logic [DIV_W:0]    rem_sh, rem_nxt;
  logic [DIV_W-1:0]  q_nxt;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
    fits   = rem_sh >= {1'b0, d_r};
    rem_nxt = fits ? rem_sh - {1'b0, d_r} : rem_sh;
    q_nxt   = {q_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== sv/zar_sqrt.sv =====
`default_nettype none
module zar_sqrt
  import zar_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SQ_IN_W-1:0]  radicand,
  output logic                     done,
  output logic      [SQ_OUT_W-1:0] root
);

  localparam int CW = $clog2(SQ_OUT_W + 1);
  localparam int RW = SQ_OUT_W + 4;

  logic                busy_r, done_r;
  logic [CW-1:0]       cnt_r;
  logic [SQ_IN_W-1:0]  x_r;
  logic [RW-1:0]       rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [RW-1:0]       rem_sh, trial, rem_nxt;
  logic [SQ_OUT_W-1:0] root_nxt;
  logic                fits;

  // One digit step: bring down two bits, try (root << 2) | 1
  always_comb begin
    rem_sh   = {rem_r[RW-3:0], x_r[SQ_IN_W-1:SQ_IN_W-2]};
    trial    = {2'b00, root_r, 2'b01};
    fits     = rem_sh >= trial;
    rem_nxt  = fits ? rem_sh - trial : rem_sh;
    root_nxt = {root_r[SQ_OUT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SQ_OUT_W);
        x_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r    <= {x_r[SQ_IN_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== tb/zar_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module zar_checker
  import zar_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic [4:0]              in_sensor_index,
  input  wire logic [TS_W-1:0]         in_time_ms,
  input  wire logic signed [VAL_W-1:0] in_sample_value,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic [1:0]              out_outcome,
  input  wire logic signed [Z_W-1:0]   out_z_score,
  input  wire logic signed [VAL_W-1:0] out_mean_after,
  input  wire logic [VAL_W-1:0]        out_stddev_after,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                           pending,
  output int                           fail_count
);

  localparam int NSENS = SENSORS_DEF;
  localparam int NHIST = HISTORY_DEF;

  typedef struct packed {
    logic [1:0]              outcome;
    logic signed [Z_W-1:0]   z;
    logic signed [VAL_W-1:0] mean;
    logic [VAL_W-1:0]        sd;
  } verdict_t;

  verdict_t verdict_q[$];

  // Register shadow
  bit [11:0] thr;
  bit [15:0] warm;
  bit [1:0]  max_al;
  bit [15:0] cool;
  bit [15:0] win;

  // Per-sensor statistics shadow
  bit [31:0]   n_seen   [NSENS];
  longint      avg      [NSENS];
  bit [63:0]   sq_sum   [NSENS];
  bit [47:0]   alert_ts [NSENS][NHIST];
  int          ts_fill  [NSENS];
  bit [47:0]   last_ts  [NSENS];
  bit          alerted  [NSENS];

  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] spread(int s);
    if (n_seen[s] < 2) return 0;
    return root_floor(sq_sum[s] / {32'd0, n_seen[s] - 32'd1});
  endfunction

  function automatic void absorb(int s, longint x);
    longint    d1;
    longint    d2;
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] p;
    if (n_seen[s] != 32'hFFFF_FFFF) n_seen[s]++;
    d1 = x - avg[s];
    avg[s] = avg[s] + d1 / longint'({32'd0, n_seen[s]});
    d2 = x - avg[s];
    a = (d1 < 0) ? -d1 : d1;
    b = (d2 < 0) ? -d2 : d2;
    p = a * b;
    if (sq_sum[s] > 64'hFFFF_FFFF_FFFF_FFFF - p) sq_sum[s] = 64'hFFFF_FFFF_FFFF_FFFF;
    else sq_sum[s] = sq_sum[s] + p;
  endfunction

  function automatic bit recent(bit [63:0] now_s, bit [63:0] then_s, bit [15:0] lim);
    return now_s >= then_s && (now_s - then_s) < {48'd0, lim};
  endfunction

  function automatic bit alert_allowed(int s, bit [47:0] t);
    bit [63:0] now_s;
    int        hits;
    now_s = t / 1000;
    if (alerted[s] && recent(now_s, last_ts[s] / 1000, cool)) return 0;
    hits = 0;
    for (int i = 0; i < ts_fill[s] && i < NHIST; i++)
      if (recent(now_s, alert_ts[s][i] / 1000, win)) hits++;
    return hits < max_al;
  endfunction

  function automatic verdict_t score_sample(int s, bit [47:0] t, longint x);
    verdict_t  r;
    bit [63:0] sd;
    bit [63:0] mag;
    bit [63:0] m;
    longint    dev;
    bit        neg;
    r = '0;
    if (n_seen[s] < warm) begin
      absorb(s, x);
    end else begin
      sd = spread(s);
      mag = 0;
      neg = 0;
      if (sd >= STD_MIN) begin
        dev = x - avg[s];
        neg = dev < 0;
        m = neg ? -dev : dev;
        mag = (m << 16) / sd;
      end
      if (neg) r.z = (mag > 64'h80_0000) ? 24'h80_0000 : -mag[23:0];
      else r.z = (mag > 64'h7F_FFFF) ? 24'h7F_FFFF : mag[23:0];
      absorb(s, x);
      if (mag > ({52'd0, thr} << 8)) begin
        if (alert_allowed(s, t)) begin
          for (int i = NHIST - 1; i > 0; i--) alert_ts[s][i] = alert_ts[s][i-1];
          alert_ts[s][0] = t;
          if (ts_fill[s] < NHIST) ts_fill[s]++;
          last_ts[s] = t;
          alerted[s] = 1;
          r.outcome = OUT_ALERT;
        end else begin
          r.outcome = OUT_SUPPRESS;
        end
      end else begin
        r.outcome = OUT_NONE;
      end
    end
    r.mean = avg[s][31:0];
    sd = spread(s);
    r.sd = sd[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      thr = RST_Z_THRESHOLD;
      warm = RST_WARMUP_COUNT;
      max_al = RST_MAX_ALERTS;
      cool = RST_COOLDOWN_SEC;
      win = RST_WINDOW_SEC;
      for (int s = 0; s < NSENS; s++) begin
        n_seen[s] = 0; avg[s] = 0; sq_sum[s] = 0; ts_fill[s] = 0;
        last_ts[s] = 0; alerted[s] = 0;
        for (int i = 0; i < NHIST; i++) alert_ts[s][i] = 0;
      end
      verdict_q.delete();
      pending = 0;
      fail_count = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_Z_THRESHOLD:  thr = cfg_wdata[11:0];
          REG_WARMUP_COUNT: warm = cfg_wdata;
          REG_MAX_ALERTS:   max_al = cfg_wdata[1:0];
          REG_COOLDOWN_SEC: cool = cfg_wdata;
          REG_WINDOW_SEC:   win = cfg_wdata;
          default: ;
        endcase
      end
      // Predict each accepted sample
      if (in_valid && !in_stall)
        verdict_q.push_back(score_sample(in_sensor_index, in_time_ms,
                                         longint'(in_sample_value)));
      // Compare each accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result outcome=%0d z=%0d mean=%0d sd=%0d", $time,
                   out_outcome, out_z_score, out_mean_after, out_stddev_after);
          fail_count++;
        end else begin
          e = verdict_q.pop_front();
          if (out_outcome !== e.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, e.outcome, out_outcome);
            fail_count++;
          end
          if (out_z_score !== e.z) begin
            $display("%0t: z_score expected %0d actual %0d", $time, e.z, out_z_score);
            fail_count++;
          end
          if (out_mean_after !== e.mean) begin
            $display("%0t: mean_after expected %0d actual %0d", $time, e.mean,
                     out_mean_after);
            fail_count++;
          end
          if (out_stddev_after !== e.sd) begin
            $display("%0t: stddev_after expected %0d actual %0d", $time, e.sd,
                     out_stddev_after);
            fail_count++;
          end
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import zar_pkg::*;

  localparam longint CYCLE_LIMIT = 8000000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 190;
  localparam int LONG_HOLD = 4000;

  // Idling modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic                    clk = 0;
  logic                    rst_n = 0;
  logic                    in_valid = 0;
  logic                    in_stall;
  logic [4:0]              in_sensor_index = 0;
  logic [TS_W-1:0]         in_time_ms = 0;
  logic signed [VAL_W-1:0] in_sample_value = 0;
  logic                    out_valid;
  logic                    out_stall = 0;
  logic [1:0]              out_outcome;
  logic signed [Z_W-1:0]   out_z_score;
  logic signed [VAL_W-1:0] out_mean_after;
  logic [VAL_W-1:0]        out_stddev_after;
  logic                    cfg_we = 0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_Z_THRESHOLD;
  logic [CFG_DATA_W-1:0]   cfg_wdata = 0;

  int     pending;
  int     fail_count;
  int     idle_mode = IDLE_NONE;
  int     hold_cycles = 0;
  bit     hold_req = 0;
  bit     hold_ack = 0;
  longint cycles = 0;
  bit [47:0] clock_ms [32];

  always #2 clk = ~clk;

  zscore_anomaly_rate_limiter u_top (.*);

  zar_checker u_chk (.*);

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: long hold-off when asked, else random stalls by mode
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= LONG_HOLD;
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall <= ($urandom_range(99) < 87);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 7);
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_sample(bit [4:0] s, bit [47:0] t, bit [31:0] v);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 87 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
    in_valid <= 1;
    in_sensor_index <= s;
    in_time_ms <= t;
    in_sample_value <= v;
    // Hold the transaction until taken
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_and_configure(bit [15:0] thr, bit [15:0] warm, bit [15:0] mx,
                                     bit [15:0] cool, bit [15:0] win);
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= REG_Z_THRESHOLD;  cfg_wdata <= thr;  @(posedge clk);
    cfg_index <= REG_WARMUP_COUNT; cfg_wdata <= warm; @(posedge clk);
    cfg_index <= REG_MAX_ALERTS;   cfg_wdata <= mx;   @(posedge clk);
    cfg_index <= REG_COOLDOWN_SEC; cfg_wdata <= cool; @(posedge clk);
    cfg_index <= REG_WINDOW_SEC;   cfg_wdata <= win;  @(posedge clk);
    cfg_we <= 0;
  endtask

  // Mostly steady readings on a few sensors with spikes; some noise
  task automatic random_sample();
    bit [4:0]  s;
    bit [47:0] t;
    bit [31:0] v;
    int        r;
    s = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(3));
    clock_ms[s] = clock_ms[s] + $urandom_range(40000);
    t = clock_ms[s];
    if ($urandom_range(99) < 3) t = 48'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < 3) v = $urandom;
    else if (r < 13) v = (s * 32'h000A_0000) + ($urandom_range(1) ? 32'h0040_0000 :
                                                                  -32'h0040_0000)
                         + $urandom_range(32'h0010_0000);
    else v = (s * 32'h000A_0000) + $urandom_range(32'h0002_0000) - 32'h0001_0000;
    send_sample(s, t, v);
  endtask

  initial begin
    bit [15:0] p_thr [PHASES] = '{640, 0, 4095, 300, 512, 200};
    bit [15:0] p_warm[PHASES] = '{20, 0, 5, 65535, 3, 10};
    bit [15:0] p_max [PHASES] = '{3, 1, 2, 3, 0, 3};
    bit [15:0] p_cool[PHASES] = '{30, 0, 65535, 10, 0, 5};
    bit [15:0] p_win [PHASES] = '{60, 1, 65535, 0, 65535, 20};
    for (int s = 0; s < 32; s++) clock_ms[s] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, constant readings, spikes, timestamp wrap-back
    drain_and_configure(0, 2, 1, 0, 1);
    send_sample(31, 0, 32'h7FFF_FFFF);
    send_sample(31, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
    send_sample(31, 1000, 32'h7FFF_FFFF);
    send_sample(31, 2000, 32'h8000_0000);
    send_sample(5, 0, 0);
    send_sample(5, 10, 0);
    send_sample(5, 20, 0);
    send_sample(6, 0, 32'h0001_0000);
    send_sample(6, 100, 32'h0002_0000);
    send_sample(6, 200, 32'h0001_8000);
    send_sample(6, 300, 32'h7FFF_FFFF);
    send_sample(6, 400, 32'h8000_0000);
    send_sample(6, 5000, 32'h7FFF_FFFF);
    send_sample(6, 1000, 32'h8000_0000);
    drain_and_configure(4095, 1, 3, 65535, 65535);
    send_sample(7, 0, 0);
    send_sample(7, 1, 32'h0000_0100);
    send_sample(7, 2, 32'h0000_0000);
    send_sample(7, 3, 32'h7FFF_0000);
    send_sample(7, 4, 32'h8000_0000);
    send_sample(0, 48'h8000_0000_0000, 32'h5555_AAAA);

    // Random phases across register settings and idling modes
    for (int p = 0; p < PHASES; p++) begin
      drain_and_configure(p_thr[p], p_warm[p], p_max[p], p_cool[p], p_win[p]);
      idle_mode = p % 4;
      if (p == 2) hold_req = ~hold_req;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          // Pause until the block is empty, then carry on
          in_valid <= 0;
          @(posedge clk);
          wait (pending == 0);
        end
        random_sample();
      end
    end
    in_valid <= 0;

    @(posedge clk);
    wait (pending == 0);
    repeat (800) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
